FILE: sv/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

    localparam logic [20:0] MIN_2BYTE  = 21'h000080;
    localparam logic [20:0] MIN_3BYTE  = 21'h000800;
    localparam logic [20:0] MIN_4BYTE  = 21'h010000;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        decode_error;
    } t_result;

    // two results per entry when a byte breaks a sequence and yields its own
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    typedef struct packed {
        logic        res_valid;
        t_result     res;
        logic [20:0] pv;
        logic [2:0]  len;
        logic [1:0]  due;
    } t_start;

    localparam t_result RES_ERROR = '{code_point: 21'd0, byte_count: LEN_NONE,
                                      decode_error: 1'b1};

    function automatic t_start start_byte(input logic [7:0] b);
        t_start s;
        s = '0;
        if (b[7] == 1'b0) begin
            s.res_valid = 1'b1;
            s.res       = '{code_point: {13'd0, b}, byte_count: LEN_1,
                            decode_error: 1'b0};
        end else if (b[7:5] == 3'b110) begin
            s.pv  = {16'd0, b[4:0]};
            s.len = LEN_2;
            s.due = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            s.pv  = {17'd0, b[3:0]};
            s.len = LEN_3;
            s.due = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            s.pv  = {18'd0, b[2:0]};
            s.len = LEN_4;
            s.due = 2'd3;
        end else begin
            s.res_valid = 1'b1;
            s.res       = RES_ERROR;
        end
        return s;
    endfunction

    function automatic t_result finish_seq(input logic [20:0] v, input logic [2:0] len);
        logic [20:0] minv;
        t_result     r;
        case (len)
            LEN_3:   minv = MIN_3BYTE;
            LEN_4:   minv = MIN_4BYTE;
            default: minv = MIN_2BYTE;
        endcase
        if (v < minv || (v >= SURR_LO && v <= SURR_HI) || v > MAX_SCALAR) begin
            r = RES_ERROR;
        end else begin
            r = '{code_point: v, byte_count: len, decode_error: 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: sv/u8d_front.sv
`timescale 1ns / 1ps

module u8d_front
    import u8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // end_of_buffer
    input  logic       i_q_full,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [20:0] r_pv, n_pv;
    logic [2:0]  r_len, n_len;
    logic [1:0]  r_due, n_due;

    logic        accept;
    logic [1:0]  cnt;
    t_result     res0, res1;
    t_start      st;

    assign s_tready = !i_q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        n_pv  = r_pv;
        n_len = r_len;
        n_due = r_due;
        cnt   = 2'd0;
        res0  = '0;
        res1  = '0;
        st    = start_byte(s_tdata);
        if (r_due == 2'd0) begin
            n_pv  = st.pv;
            n_len = st.len;
            n_due = st.due;
            if (st.res_valid) begin
                res0 = st.res;
                cnt  = 2'd1;
            end
        end else if (s_tdata[7:6] == 2'b10) begin
            n_pv  = {r_pv[14:0], s_tdata[5:0]};
            n_due = r_due - 2'd1;
            if (n_due == 2'd0) begin
                res0  = finish_seq(n_pv, r_len);
                cnt   = 2'd1;
                n_pv  = '0;
                n_len = LEN_NONE;
            end
        end else begin
            // broken sequence, then the byte starts over
            res0  = RES_ERROR;
            cnt   = 2'd1;
            n_pv  = st.pv;
            n_len = st.len;
            n_due = st.due;
            if (st.res_valid) begin
                res1 = st.res;
                cnt  = 2'd2;
            end
        end
        if (s_tlast && n_due != 2'd0) begin
            if (cnt == 2'd0) begin
                res0 = RES_ERROR;
                cnt  = 2'd1;
            end else begin
                res1 = RES_ERROR;
                cnt  = 2'd2;
            end
            n_pv  = '0;
            n_len = LEN_NONE;
            n_due = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= '0;
            r_len <= LEN_NONE;
            r_due <= 2'd0;
        end else if (accept) begin
            r_pv  <= n_pv;
            r_len <= n_len;
            r_due <= n_due;
        end
    end

    assign o_push        = accept && (cnt != 2'd0);
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.r0    = res0;
    assign o_entry.r1    = res1;

endmodule

FILE: sv/u8d_queue.sv
`timescale 1ns / 1ps

module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/u8d_back.sv
`timescale 1ns / 1ps

module u8d_back
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // code_point[20:0], byte_count[23:21]
    output logic [0:0]  m_tuser,   // decode_error
    output logic        m_tlast    // last_of_run
);

    logic    r_valid;
    logic    r_sel;
    t_result r_res;
    logic    r_last;
    logic    load;
    logic    is_last;
    t_result pick;

    assign load    = !i_empty && (!r_valid || m_tready);
    assign is_last = !i_head.two || r_sel;
    assign pick    = r_sel ? i_head.r1 : i_head.r0;
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !is_last;
            end else if (m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= pick;
            r_last <= is_last;
        end
    end

    assign m_tvalid   = r_valid;
    assign m_tdata    = {r_res.byte_count, r_res.code_point};
    assign m_tuser[0] = r_res.decode_error;
    assign m_tlast    = r_last;

endmodule

FILE: sv/utf8_stream_decoder_core.sv
// An accepted byte is decoded combinationally, written into the queue, then loaded
// into the output register. Throughput: one byte per cycle while the queue is not
// full; a byte that yields two results sends them in turn, absorbed by the front/back queue.
// Reset: synchronous active-low i_rst_n clears the open sequence, the queue
// and the output register.
`timescale 1ns / 1ps

module utf8_stream_decoder_core
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // code_point[20:0], byte_count[23:21]
    output logic [0:0]  m_tuser,   // decode_error
    output logic        m_tlast    // last_of_run
);

    logic   q_full, q_empty, q_push, q_pop;
    t_entry q_in, q_head;

    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    u8d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 24'd0))
        else $error("error item carries data");

    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[23:21] != 3'd0 && m_tdata[23:21] <= 3'd4))
        else $error("bad byte count on good item");
`endif

endmodule
